// ===== sv/lsps_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and sizes for the status led pattern sequencer
// no dependencies; imported by every module of the block
package lsps_pkg;

  // width of the millisecond time base and of the deadline
  localparam int TIME_WIDTH = 32;
  // width of the remainder unit's bit counter
  localparam int CNT_W = $clog2(TIME_WIDTH + 1);
  // timing register width and register file size
  localparam int REG_W = 16;
  localparam int ADDR_W = 5;

  // action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_NOTIFY = 2'd1;
  localparam logic [1:0] ACT_MODE = 2'd2;

  // mode codes
  localparam logic [1:0] MODE_BOOTING = 2'd0;
  localparam logic [1:0] MODE_CONNECTING = 2'd1;
  localparam logic [1:0] MODE_RUNNING = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FAST_ON = 3'd0;
  localparam logic [2:0] REG_FAST_PERIOD = 3'd1;
  localparam logic [2:0] REG_BEAT_ON = 3'd2;
  localparam logic [2:0] REG_BEAT_PERIOD = 3'd3;
  localparam logic [2:0] REG_PULSE = 3'd4;
  localparam logic [2:0] REG_GAP = 3'd5;

  // register reset values
  localparam logic [REG_W-1:0] FAST_ON_RST = 16'd125;
  localparam logic [REG_W-1:0] FAST_PERIOD_RST = 16'd250;
  localparam logic [REG_W-1:0] BEAT_ON_RST = 16'd100;
  localparam logic [REG_W-1:0] BEAT_PERIOD_RST = 16'd2000;
  localparam logic [REG_W-1:0] PULSE_RST = 16'd80;
  localparam logic [REG_W-1:0] GAP_RST = 16'd80;

  // blink phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PULSE1 = 3'd1,
    PH_GAP1   = 3'd2,
    PH_PULSE2 = 3'd3,
    PH_GAP2   = 3'd4
  } phase_t;

  // sequencer state
  typedef enum logic {
    SEQ_IDLE,
    SEQ_DIV
  } seq_state_t;

  // input and result words
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_now;
    logic [1:0]  mode_value;
  } in_word_t;

  typedef struct packed {
    logic led_update;
    logic led_level;
  } out_word_t;

  // timing registers as seen by the sequencer
  typedef struct packed {
    logic [REG_W-1:0] fast_on_ms;
    logic [REG_W-1:0] fast_period_ms;
    logic [REG_W-1:0] beat_on_ms;
    logic [REG_W-1:0] beat_period_ms;
    logic [REG_W-1:0] pulse_ms;
    logic [REG_W-1:0] gap_ms;
  } cfg_t;

  // remainder unit status
  typedef struct packed {
    logic             done;
    logic [REG_W-1:0] rem;
  } rem_status_t;

endpackage

// ===== sv/lsps_regs.sv =====
`timescale 1ns / 1ps
// apb-style timing register file, six 16-bit registers at word addresses
// depends on lsps_pkg
module lsps_regs
  import lsps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_on_ms     <= FAST_ON_RST;
      cfg.fast_period_ms <= FAST_PERIOD_RST;
      cfg.beat_on_ms     <= BEAT_ON_RST;
      cfg.beat_period_ms <= BEAT_PERIOD_RST;
      cfg.pulse_ms       <= PULSE_RST;
      cfg.gap_ms         <= GAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FAST_ON:     cfg.fast_on_ms     <= pwdata[REG_W-1:0];
        REG_FAST_PERIOD: cfg.fast_period_ms <= pwdata[REG_W-1:0];
        REG_BEAT_ON:     cfg.beat_on_ms     <= pwdata[REG_W-1:0];
        REG_BEAT_PERIOD: cfg.beat_period_ms <= pwdata[REG_W-1:0];
        REG_PULSE:       cfg.pulse_ms       <= pwdata[REG_W-1:0];
        REG_GAP:         cfg.gap_ms         <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_FAST_ON:     prdata = {16'd0, cfg.fast_on_ms};
      REG_FAST_PERIOD: prdata = {16'd0, cfg.fast_period_ms};
      REG_BEAT_ON:     prdata = {16'd0, cfg.beat_on_ms};
      REG_BEAT_PERIOD: prdata = {16'd0, cfg.beat_period_ms};
      REG_PULSE:       prdata = {16'd0, cfg.pulse_ms};
      REG_GAP:         prdata = {16'd0, cfg.gap_ms};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/lsps_rem.sv =====
`timescale 1ns / 1ps
// bit-serial restoring remainder unit: time modulo a 16-bit period
// depends on lsps_pkg; one dividend bit per cycle
module lsps_rem
  import lsps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] dividend,
  input  logic [REG_W-1:0]      divisor,
  output rem_status_t           status
);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic [TIME_WIDTH-1:0] shreg;
  logic [REG_W-1:0]      dvsr;
  logic [REG_W-1:0]      rem;
  logic [REG_W:0]        trial;
  logic [REG_W:0]        diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, shreg[TIME_WIDTH-1]};
  assign diff  = trial - {1'b0, dvsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(TIME_WIDTH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvsr  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[TIME_WIDTH-2:0], 1'b0};
      if (!diff[REG_W]) begin
        rem <= diff[REG_W-1:0];
      end else begin
        rem <= trial[REG_W-1:0];
      end
    end
  end

  assign status.done = done;
  assign status.rem  = rem;

endmodule

// ===== sv/led_status_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// status led pattern sequencer top level: item sequencer and result register
// depends on lsps_pkg, lsps_regs, lsps_rem
//
//   channel  | direction | handshake             | word
//   in       | into      | in_valid / in_ready   | in_word_t (action, time_now, mode_value)
//   out      | out of    | out_valid / out_ready | out_word_t (led_update, led_level)
//   apb      | into      | psel/penable, pready  | six 16-bit timing registers
//
// a tick that lands on a pattern level in connecting or running mode with a
// nonzero period takes its result from the remainder unit, which retires one
// time bit per cycle; every other item gives its result in the cycle after
// acceptance.
// one item is in flight at a time; a new word is taken once the result
// register is empty or being emptied. reset is synchronous and needs no pass.
module led_status_pattern_sequencer
  import lsps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t        cfg;
  rem_status_t rem_st;

  seq_state_t            seq, seq_next;
  phase_t                phase, phase_next;
  logic [TIME_WIDTH-1:0] deadline, deadline_next;
  logic                  pending, pending_next;
  logic [1:0]            mode, mode_next;
  logic                  led_held;
  logic [REG_W-1:0]      on_lat;

  logic                  accept;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] since;
  logic                  due;
  logic                  start_div;
  logic                  drive;
  logic                  level;
  logic [REG_W-1:0]      sel_period;
  logic [REG_W-1:0]      sel_on;
  logic                  load;
  out_word_t             load_word;

  lsps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsps_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (start_div),
    .dividend (now),
    .divisor  (sel_period),
    .status   (rem_st)
  );

  // wrap-safe deadline check
  assign accept = in_valid && in_ready;
  assign now    = TIME_WIDTH'(in_data.time_now);
  assign since  = now - deadline;
  assign due    = !since[TIME_WIDTH-1];

  // pattern source for the current mode
  always_comb begin
    if (mode == MODE_CONNECTING) begin
      sel_period = cfg.fast_period_ms;
      sel_on     = cfg.fast_on_ms;
    end else begin
      sel_period = cfg.beat_period_ms;
      sel_on     = cfg.beat_on_ms;
    end
  end

  // item decode and state update
  always_comb begin
    phase_next    = phase;
    deadline_next = deadline;
    pending_next  = pending;
    mode_next     = mode;
    start_div     = 1'b0;
    drive         = 1'b0;
    level         = 1'b0;
    if (accept) begin
      case (in_data.action)
        ACT_NOTIFY: begin
          if (mode == MODE_RUNNING) begin
            pending_next = 1'b1;
          end
        end
        ACT_MODE: begin
          if (in_data.mode_value == MODE_BOOTING || in_data.mode_value == MODE_CONNECTING ||
              in_data.mode_value == MODE_RUNNING) begin
            mode_next     = in_data.mode_value;
            phase_next    = PH_IDLE;
            deadline_next = '0;
            pending_next  = 1'b0;
          end
        end
        ACT_TICK: begin
          if (due) begin
            unique case (phase)
              PH_IDLE: begin
                drive = 1'b1;
                if (mode == MODE_RUNNING && pending) begin
                  pending_next  = 1'b0;
                  level         = 1'b1;
                  phase_next    = PH_PULSE1;
                  deadline_next = now + TIME_WIDTH'(cfg.pulse_ms);
                end else if (mode == MODE_BOOTING) begin
                  level = 1'b1;
                end else if (sel_period == '0) begin
                  // zero period: the remainder is the time itself
                  level = now < TIME_WIDTH'(sel_on);
                end else begin
                  start_div = 1'b1;
                end
              end
              PH_PULSE1, PH_PULSE2: begin
                drive         = 1'b1;
                level         = 1'b0;
                phase_next    = (phase == PH_PULSE1) ? PH_GAP1 : PH_GAP2;
                deadline_next = now + TIME_WIDTH'(cfg.gap_ms);
              end
              PH_GAP1: begin
                drive         = 1'b1;
                level         = 1'b1;
                phase_next    = PH_PULSE2;
                deadline_next = now + TIME_WIDTH'(cfg.pulse_ms);
              end
              default: begin
                // end of second gap: back to idle, led untouched
                phase_next    = PH_IDLE;
                deadline_next = now;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // result word to load this cycle
  always_comb begin
    load      = 1'b0;
    load_word = '0;
    if (rem_st.done) begin
      load                 = 1'b1;
      load_word.led_update = 1'b1;
      load_word.led_level  = rem_st.rem < on_lat;
    end else if (accept && !start_div) begin
      load                 = 1'b1;
      load_word.led_update = drive;
      load_word.led_level  = drive ? level : led_held;
    end
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: if (start_div) seq_next = SEQ_DIV;
      SEQ_DIV:  if (rem_st.done) seq_next = SEQ_IDLE;
      default:  seq_next = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    unique case (seq)
      SEQ_IDLE: in_ready = !out_valid || out_ready;
      default:  in_ready = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      phase     <= PH_IDLE;
      deadline  <= '0;
      pending   <= 1'b0;
      mode      <= MODE_BOOTING;
      led_held  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      seq      <= seq_next;
      phase    <= phase_next;
      deadline <= deadline_next;
      pending  <= pending_next;
      mode     <= mode_next;
      if (load) begin
        out_valid <= 1'b1;
        led_held  <= load_word.led_level;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_div) begin
      on_lat <= sel_on;
    end
    if (load) begin
      out_data <= load_word;
    end
  end

endmodule
